### src/todpt_pkg.sv
package todpt_pkg;

	localparam int KeyCount = 10;
	localparam int TableLen = 10;
	localparam int KeyLimit = (KeyCount > TableLen) ? TableLen : KeyCount;
	localparam int KeyIdxW  = $clog2(TableLen);

	localparam int NumChan  = 3;
	localparam int HourW    = 13;
	localparam int GainW    = 9;
	localparam int ProdW    = GainW + HourW;
	localparam int NumW     = ProdW + 1;
	localparam int PixW     = 16;

	localparam logic [HourW-1:0] HourMax = 13'd6144;
	localparam logic [GainW-1:0] GainUnity = 9'd256;

	// keyframe hours, Q5.8
	localparam logic [HourW-1:0] KeyHour [TableLen] = '{
		13'd0, 13'd1280, 13'd1664, 13'd1920, 13'd2304,
		13'd4352, 13'd4736, 13'd5120, 13'd5504, 13'd6144
	};

	// keyframe gains, Q1.8, red / green / blue
	localparam logic [GainW-1:0] KeyGain [TableLen][NumChan] = '{
		'{9'd77,  9'd108, 9'd154},
		'{9'd77,  9'd108, 9'd154},
		'{9'd141, 9'd118, 9'd113},
		'{9'd243, 9'd200, 9'd159},
		'{9'd256, 9'd256, 9'd256},
		'{9'd256, 9'd256, 9'd256},
		'{9'd256, 9'd184, 9'd128},
		'{9'd141, 9'd118, 9'd118},
		'{9'd77,  9'd108, 9'd154},
		'{9'd77,  9'd108, 9'd154}
	};

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,
		OP_BLEND = 2'd1,
		OP_KEY   = 2'd2,
		OP_UNITY = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [KeyIdxW-1:0] key;
		logic [HourW-1:0]   hour_off;
		logic [PixW-1:0]    pix;
	} entry_t;

	localparam int FifoDepth = 4;
	localparam int FifoPtrW  = $clog2(FifoDepth);
	localparam int FifoCntW  = $clog2(FifoDepth + 1);

	typedef logic [NumW-1:0]  num_arr_t  [NumChan];
	typedef logic [GainW-1:0] gain_arr_t [NumChan];

endpackage

### src/time_of_day_pixel_tint.sv
// Channel   Handshake            Payload
// input     push / full          kind, hour_q, pixel_in
// result    empty / pop          pixel_out
// config    cfg_valid/cfg_ready  cfg_data (day_night_enable)
//
// Pixels stream at one transaction per clock while no blend or full result
// slot holds the back end; a pushed pixel passes the queue and lands in
// the result register on pixel_out. A blending time update holds the back
// end while the three-lane serial divider forms the gains; later items queue.
// Reset: gains unity, day-night enabled, queue and result slot empty.
// A four-entry queue decouples push from pop; cfg_ready is always high.
module time_of_day_pixel_tint (
	input  logic        clk,
	input  logic        arst_n,
	// input queue side
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [15:0] hour_q,
	input  logic [15:0] pixel_in,
	// result queue side
	output logic        empty,
	input  logic        pop,
	output logic [15:0] pixel_out,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import todpt_pkg::*;

	entry_t front_entry;
	entry_t head_entry;
	logic   q_empty;
	logic   q_pop;

	// front: config register, hour clamp, keyframe segment search, op classification
	todpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.kind      (kind),
		.hour_q    (hour_q),
		.pixel_in  (pixel_in),
		.entry     (front_entry)
	);

	// classified transactions wait here; full backs up the pusher
	todpt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (front_entry),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (head_entry)
	);

	// back: gain update or pixel tint, result register on the way out
	todpt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (q_empty),
		.entry      (head_entry),
		.fifo_pop   (q_pop),
		.empty      (empty),
		.pop        (pop),
		.pixel_out  (pixel_out)
	);

endmodule

### src/todpt_front.sv
module todpt_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_data,
	input  logic                    kind,
	input  logic [15:0]             hour_q,
	input  logic [15:0]             pixel_in,
	output todpt_pkg::entry_t       entry
);
	import todpt_pkg::*;

	logic               enable_q;
	logic [HourW-1:0]   hu;
	logic               found;
	logic [KeyIdxW-1:0] seg;
	logic [KeyIdxW-1:0] prev;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid) begin
			enable_q <= cfg_data;
		end
	end

	// clamp to 0..24 h
	always_comb begin
		if (hour_q[15]) begin
			hu = '0;
		end else if (hour_q[14:0] > 15'(HourMax)) begin
			hu = HourMax;
		end else begin
			hu = hour_q[HourW-1:0];
		end
	end

	// first key at or above the hour; lowest index wins
	always_comb begin
		found = 1'b0;
		seg   = KeyIdxW'(KeyLimit - 1);
		for (int i = KeyLimit - 1; i >= 1; i--) begin
			if (hu <= KeyHour[i]) begin
				found = 1'b1;
				seg   = KeyIdxW'(i);
			end
		end
	end

	assign prev = seg - KeyIdxW'(1);

	always_comb begin
		entry.pix      = pixel_in;
		entry.key      = seg;
		entry.hour_off = (hu > KeyHour[prev]) ? hu - KeyHour[prev] : '0;
		if (kind) begin
			entry.op = OP_PIXEL;
		end else if (!enable_q) begin
			entry.op = OP_UNITY;
		end else if (!found) begin
			entry.op = OP_KEY;
		end else if (KeyHour[seg] == KeyHour[prev]) begin
			entry.op  = OP_KEY;
			entry.key = prev;
		end else begin
			entry.op = OP_BLEND;
		end
	end

endmodule

### src/todpt_fifo.sv
module todpt_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  todpt_pkg::entry_t wdata,
	input  logic              pop,
	output logic              empty,
	output todpt_pkg::entry_t rdata
);
	import todpt_pkg::*;

	entry_t              mem_q [FifoDepth];
	logic [FifoPtrW-1:0] wr_q;
	logic [FifoPtrW-1:0] rd_q;
	logic [FifoCntW-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == FifoCntW'(FifoDepth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + FifoPtrW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + FifoPtrW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + FifoCntW'(1);
				2'b01:   count_q <= count_q - FifoCntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FifoCntW'(FifoDepth))
		else $error("fifo count past depth");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + FifoCntW'(1)))
		else $error("fifo count missed a write");
`endif

endmodule

### src/todpt_div.sv
module todpt_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  todpt_pkg::num_arr_t       num,
	input  logic [todpt_pkg::HourW-1:0] den,
	output logic                      busy,
	output todpt_pkg::gain_arr_t      quo
);
	import todpt_pkg::*;

	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0]  nq_q  [NumChan];
	logic [HourW-1:0] rem_q [NumChan];
	logic [HourW-1:0] den_q;
	logic [CntW-1:0]  cnt_q;
	logic [HourW:0]   sh    [NumChan];
	logic             ge    [NumChan];

	assign busy = (cnt_q != '0);

	// one restoring step per cycle, three lanes sharing the count
	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			sh[c]  = {rem_q[c], nq_q[c][NumW-1]};
			ge[c]  = (sh[c] >= {1'b0, den_q});
			quo[c] = nq_q[c][GainW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			for (int c = 0; c < NumChan; c++) begin
				nq_q[c]  <= num[c];
				rem_q[c] <= '0;
			end
		end else if (busy) begin
			for (int c = 0; c < NumChan; c++) begin
				nq_q[c]  <= {nq_q[c][NumW-2:0], ge[c]};
				rem_q[c] <= ge[c] ? HourW'(sh[c] - {1'b0, den_q}) : sh[c][HourW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(NumW);
		end else if (busy) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

endmodule

### src/todpt_back.sv
module todpt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fifo_empty,
	input  todpt_pkg::entry_t    entry,
	output logic                 fifo_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [15:0]          pixel_out
);
	import todpt_pkg::*;

	typedef enum logic [3:0] {
		ST_RUN = 4'b0001,
		ST_MUL = 4'b0010,
		ST_SUM = 4'b0100,
		ST_DIV = 4'b1000
	} back_state_t;

	back_state_t        state_q;
	logic [GainW-1:0]   gain_q [NumChan];
	logic [KeyIdxW-1:0] seg_q;
	logic [KeyIdxW-1:0] prev;
	logic [HourW-1:0]   dist_q;
	logic [HourW-1:0]   span;
	logic [ProdW-1:0]   prod_a_q [NumChan];
	logic [ProdW-1:0]   prod_c_q [NumChan];
	num_arr_t           num;
	gain_arr_t          quo;
	logic               div_start;
	logic               div_busy;
	logic               out_valid_q;
	logic [PixW-1:0]    out_q;
	logic               slot_free;
	logic               take_pix;
	logic [13:0]        prod_r;
	logic [14:0]        prod_g;
	logic [13:0]        prod_b;
	logic [4:0]         ch_r;
	logic [5:0]         ch_g;
	logic [4:0]         ch_b;

	assign empty     = !out_valid_q;
	assign pixel_out = out_q;
	assign slot_free = !out_valid_q || pop;
	assign fifo_pop  = (state_q == ST_RUN) && !fifo_empty
		&& ((entry.op != OP_PIXEL) || slot_free);
	assign take_pix  = fifo_pop && (entry.op == OP_PIXEL);

	// pixel scaling, floor then saturate
	always_comb begin
		prod_r = 14'(entry.pix[15:11]) * 14'(gain_q[0]);
		prod_g = 15'(entry.pix[10:5])  * 15'(gain_q[1]);
		prod_b = 14'(entry.pix[4:0])   * 14'(gain_q[2]);
		ch_r   = (prod_r[13:8] > 6'd31) ? 5'd31 : prod_r[12:8];
		ch_g   = (prod_g[14:8] > 7'd63) ? 6'd63 : prod_g[13:8];
		ch_b   = (prod_b[13:8] > 6'd31) ? 5'd31 : prod_b[12:8];
	end

	assign prev = seg_q - KeyIdxW'(1);
	assign span = KeyHour[seg_q] - KeyHour[prev];

	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			num[c] = NumW'(prod_a_q[c]) + NumW'(prod_c_q[c]) + NumW'(span >> 1);
		end
	end

	assign div_start = (state_q == ST_SUM);

	todpt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (span),
		.busy   (div_busy),
		.quo    (quo)
	);

	always_ff @(posedge clk) begin
		if (take_pix) begin
			out_q <= {ch_r, ch_g, ch_b};
		end
		if (fifo_pop) begin
			seg_q  <= entry.key;
			dist_q <= entry.hour_off;
		end
		if (state_q == ST_MUL) begin
			for (int c = 0; c < NumChan; c++) begin
				prod_a_q[c] <= ProdW'(KeyGain[prev][c]) * ProdW'(span - dist_q);
				prod_c_q[c] <= ProdW'(KeyGain[seg_q][c]) * ProdW'(dist_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
			for (int c = 0; c < NumChan; c++) begin
				gain_q[c] <= GainUnity;
			end
		end else begin
			if (take_pix) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RUN: begin
					if (fifo_pop) begin
						unique case (entry.op)
							OP_BLEND: state_q <= ST_MUL;
							OP_KEY: begin
								for (int c = 0; c < NumChan; c++) begin
									gain_q[c] <= KeyGain[entry.key][c];
								end
							end
							OP_UNITY: begin
								for (int c = 0; c < NumChan; c++) begin
									gain_q[c] <= GainUnity;
								end
							end
							default: state_q <= ST_RUN;
						endcase
					end
				end
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_DIV;
				ST_DIV: begin
					if (!div_busy) begin
						gain_q  <= quo;
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

`ifndef SYNTH
	a_div_idle_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !div_busy)
		else $error("divider running while back end streams pixels");

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(gain_q[0] <= GainUnity) && (gain_q[1] <= GainUnity) && (gain_q[2] <= GainUnity))
		else $error("gain above unity");
`endif

endmodule
